FILE: rtl/assert_macros.svh
// Assertion helpers shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define FRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define FRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/frt_pkg.sv
package frt_pkg;

  localparam int MAX_RANGES  = 16;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_RANGES);
  localparam int CNT_W       = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] ST_MERGED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  typedef struct packed {
    logic [31:0] range_begin;
    logic [15:0] range_length;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  range_count;
    logic [31:0] bytes_received;
    logic        complete;
  } out_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS:0]   stop;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic tail;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic list_empty;
    logic hold;
    logic last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/frt_ram.sv
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/frt_ctrl.sv
`include "assert_macros.svh"

module frt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  frt_pkg::sts_t sts,
  output frt_pkg::cmd_t cmd,
  output logic          idle
);

  frt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frt_pkg::S_IDLE: begin
        if (in_valid) begin
          if (sts.len_zero) begin
            state_nxt = frt_pkg::S_DONE;
          end else if (sts.list_empty) begin
            state_nxt = frt_pkg::S_TAIL;
          end else begin
            state_nxt = frt_pkg::S_EVAL;
          end
        end
      end
      frt_pkg::S_EVAL: begin
        if (!sts.hold && sts.last) begin
          state_nxt = frt_pkg::S_TAIL;
        end
      end
      frt_pkg::S_TAIL: begin
        state_nxt = frt_pkg::S_DONE;
      end
      frt_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt = frt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = frt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      frt_pkg::S_IDLE: begin
        idle       = 1'b1;
        cmd.accept = in_valid;
      end
      frt_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
      end
      frt_pkg::S_TAIL: begin
        cmd.tail = 1'b1;
      end
      frt_pkg::S_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `FRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd.accept, !idle)
  `FRT_ASSERT_NEXT(a_emit_idle, clk, rst_n, cmd.emit, idle)

endmodule

FILE: rtl/frt_dpath.sv
`include "assert_macros.svh"

module frt_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  frt_pkg::cmd_t cmd,
  output frt_pkg::sts_t sts,
  input  frt_pkg::in_t  in_data,
  input  logic          cfg_wr,
  input  logic [31:0]   cfg_data,
  input  logic          out_stall,
  output logic          out_valid,
  output frt_pkg::out_t out_data
);

  localparam int OB    = frt_pkg::OFFSET_BITS;
  localparam int CW    = frt_pkg::CNT_W;
  localparam int IW    = frt_pkg::IDX_W;
  localparam int EW    = frt_pkg::ENTRY_W;
  localparam int SUM_W = OB + 2;
  localparam logic [CW-1:0] MAXC = CW'(frt_pkg::MAX_RANGES);

  logic [31:0]    exp_r;
  logic [CW-1:0]  total_r;
  logic [31:0]    bytes_r;
  logic [OB-1:0]  head_start_r;
  logic [OB:0]    head_stop_r;
  logic           bank_r;
  logic [OB-1:0]  cur_b_r;
  logic [OB:0]    cur_e_r;
  logic [CW-1:0]  i_r;
  logic [CW-1:0]  k_r;
  logic           placed_r;
  logic           merged_r;
  logic [31:0]    sum_r;
  frt_pkg::entry_t pend_r;
  logic [1:0]     code_r;
  logic           out_valid_r;
  frt_pkg::out_t  out_data_r;

  logic [EW-1:0]  rd0, rd1;
  frt_pkg::entry_t ent, wdata;
  logic           below, above, hold, we_raw, we_q, re, commit, complete;
  logic [CW-1:0]  i_inc, k_nxt;
  logic [IW-1:0]  raddr;
  logic [OB:0]    diff;
  logic [SUM_W-1:0] sum_add;
  logic [31:0]    sum_nxt;
  frt_pkg::entry_t pend_nxt;

  assign ent   = bank_r ? frt_pkg::entry_t'(rd1) : frt_pkg::entry_t'(rd0);
  assign below = ent.stop < {1'b0, cur_b_r};
  assign above = {1'b0, ent.start} > cur_e_r;
  assign hold  = !below && above && !placed_r;

  assign we_raw = (cmd.eval && (below || above)) || (cmd.tail && !placed_r);
  assign we_q   = we_raw && (k_r < MAXC);
  assign wdata  = (cmd.tail || hold) ? frt_pkg::entry_t'({cur_b_r, cur_e_r}) : ent;

  assign i_inc = i_r + CW'(1);
  assign re    = cmd.accept || (cmd.eval && !hold);
  assign raddr = cmd.eval ? i_inc[IW-1:0] : '0;

  assign diff    = wdata.stop - {1'b0, wdata.start};
  assign sum_add = SUM_W'(sum_r) + SUM_W'(diff);
  assign sum_nxt = !we_q ? sum_r : ((sum_add[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                : sum_add[31:0]);
  assign k_nxt    = we_q ? k_r + CW'(1) : k_r;
  assign pend_nxt = (we_q && k_r == '0) ? wdata : pend_r;
  assign commit   = merged_r || (total_r != MAXC);

  assign complete = (total_r == CW'(1)) && (head_start_r == '0) && (exp_r != '0) &&
                    (head_stop_r >= (OB + 1)'(exp_r));

  frt_ram #(.WIDTH(EW), .DEPTH(frt_pkg::MAX_RANGES)) u_bank0 (
    .clk   (clk),
    .we    (we_q && bank_r),
    .waddr (k_r[IW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd0)
  );

  frt_ram #(.WIDTH(EW), .DEPTH(frt_pkg::MAX_RANGES)) u_bank1 (
    .clk   (clk),
    .we    (we_q && !bank_r),
    .waddr (k_r[IW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= '0;
      total_r     <= '0;
      bytes_r     <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        exp_r   <= cfg_data;
        total_r <= '0;
        bytes_r <= '0;
      end else if (cmd.tail && commit) begin
        total_r <= k_nxt;
        bytes_r <= sum_nxt;
        bank_r  <= !bank_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_b_r  <= in_data.range_begin[OB-1:0];
      cur_e_r  <= (OB + 1)'(in_data.range_begin[OB-1:0]) + (OB + 1)'(in_data.range_length);
      i_r      <= '0;
      k_r      <= '0;
      placed_r <= 1'b0;
      merged_r <= 1'b0;
      sum_r    <= '0;
      code_r   <= (in_data.range_length == '0) ? frt_pkg::ST_ZERO : frt_pkg::ST_MERGED;
    end else begin
      k_r    <= k_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      if (cmd.eval) begin
        if (hold) begin
          placed_r <= 1'b1;
        end else begin
          i_r <= i_inc;
          if (!below && !above) begin
            merged_r <= 1'b1;
            if (ent.start < cur_b_r) begin
              cur_b_r <= ent.start;
            end
            if (ent.stop > cur_e_r) begin
              cur_e_r <= ent.stop;
            end
          end
        end
      end
      if (cmd.tail) begin
        placed_r <= 1'b1;
        code_r   <= commit ? frt_pkg::ST_MERGED : frt_pkg::ST_FULL;
        if (commit) begin
          head_start_r <= pend_nxt.start;
          head_stop_r  <= pend_nxt.stop;
        end
      end
    end
    if (cmd.emit) begin
      out_data_r.status         <= code_r;
      out_data_r.range_count    <= total_r;
      out_data_r.bytes_received <= bytes_r;
      out_data_r.complete       <= complete;
    end
  end

  assign sts.len_zero   = (in_data.range_length == '0);
  assign sts.list_empty = (total_r == '0);
  assign sts.hold       = hold;
  assign sts.last       = (i_inc == total_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FRT_ASSERT(a_total_bound, clk, rst_n, total_r <= MAXC)
  `FRT_ASSERT(a_write_bound, clk, rst_n, !we_q || (k_r < MAXC))
  `FRT_ASSERT_NEXT(a_hold_once, clk, rst_n, cmd.eval && hold, placed_r)

endmodule

FILE: rtl/fragment_range_tracker.sv
// Sequence: after accept, S_EVAL walks the n stored ranges, pausing once when the
//   fragment becomes a new range ahead of a stored one, then S_TAIL and S_DONE
//   lead to out_valid; an empty list skips S_EVAL, a zero-length fragment goes to S_DONE.
// Throughput: one fragment at a time; the S_EVAL walk reads one entry per cycle
//   over the range RAM read port, except while it pauses to place the fragment.
// Reset: synchronous, active low; clears the range count, expected size and handshakes.
module fragment_range_tracker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  frt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output frt_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  frt_pkg::cmd_t cmd;
  frt_pkg::sts_t sts;
  logic          idle;

  assign in_stall  = !idle;
  assign cfg_ready = idle && !in_valid;

  frt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  frt_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
